/* rtl/core/lar_pkg.sv */
`default_nettype none

package lar_pkg;

  localparam int unsigned QuatFracBits = 14;
  localparam int unsigned UnitFracBits = 30;
  localparam logic [15:0] MinDistReset = 16'd7;

  // serial unit widths
  localparam int unsigned OpW   = 32;
  localparam int unsigned WordW = 64;
  localparam int unsigned DenW  = 33;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic               degenerate;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIST_SQ,
    ST_DIST_MIN,
    ST_LOAD_Z,
    ST_SAVE_Z,
    ST_SAVE_X,
    ST_CROSS,
    ST_SAVE_Y,
    ST_ROOT,
    ST_QUOT,
    ST_SAVE_Q,
    ST_NRM_MAG,
    ST_NRM_SCALE,
    ST_NRM_SQ,
    ST_NRM_ROOT,
    ST_NRM_DIV,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

/* rtl/core/lar_mul.sv */
`default_nettype none

module lar_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lar_pkg::OpW-1:0]    a_i,
  input  logic [lar_pkg::OpW-1:0]    b_i,
  output logic                       done_o,
  output logic [lar_pkg::WordW-1:0]  prod_o
);

  localparam int unsigned CntW = $clog2(lar_pkg::OpW);

  logic [lar_pkg::WordW-1:0] a_q;
  logic [lar_pkg::WordW-1:0] p_q;
  logic [lar_pkg::OpW-1:0]   b_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q;
  logic                      done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift-add, one multiplier bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= {{(lar_pkg::WordW-lar_pkg::OpW){1'b0}}, a_i};
      b_q <= b_i;
      p_q <= '0;
    end else if (busy_q) begin
      if (b_q[0]) begin
        p_q <= p_q + a_q;
      end
      a_q <= a_q << 1;
      b_q <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

`default_nettype wire

/* rtl/core/lar_div.sv */
`default_nettype none

module lar_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lar_pkg::WordW-1:0]  num_i,
  input  logic [lar_pkg::DenW-1:0]   den_i,
  output logic                       done_o,
  output logic [lar_pkg::WordW-1:0]  quo_o
);

  localparam int unsigned CntW = $clog2(lar_pkg::WordW);

  logic [lar_pkg::DenW-1:0]  rem_q;
  logic [lar_pkg::DenW-1:0]  den_q;
  logic [lar_pkg::WordW-1:0] quo_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [lar_pkg::DenW:0]    shifted;
  logic [lar_pkg::DenW:0]    trial;

  assign shifted = {rem_q, quo_q[lar_pkg::WordW-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      if (!trial[lar_pkg::DenW]) begin
        rem_q <= trial[lar_pkg::DenW-1:0];
        quo_q <= {quo_q[lar_pkg::WordW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[lar_pkg::DenW-1:0];
        quo_q <= {quo_q[lar_pkg::WordW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

/* rtl/core/lar_sqrt.sv */
`default_nettype none

module lar_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lar_pkg::WordW-1:0]  val_i,
  output logic                       done_o,
  output logic [lar_pkg::OpW-1:0]    root_o
);

  localparam int unsigned CntW = $clog2(lar_pkg::OpW);
  localparam int unsigned RemW = lar_pkg::OpW + 2;

  logic [lar_pkg::WordW-1:0] val_q;
  logic [RemW-1:0]           rem_q;
  logic [lar_pkg::OpW-1:0]   root_q;
  logic [CntW-1:0]           cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [RemW+1:0]           shifted;
  logic [RemW+1:0]           trial;

  assign shifted = {rem_q, val_q[lar_pkg::WordW-1 -: 2]};
  assign trial   = shifted - {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // floor root, two radicand bits a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= val_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q <= val_q << 2;
      if (!trial[RemW+1]) begin
        rem_q  <= trial[RemW-1:0];
        root_q <= {root_q[lar_pkg::OpW-2:0], 1'b1};
      end else begin
        rem_q  <= shifted[RemW-1:0];
        root_q <= {root_q[lar_pkg::OpW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

/* rtl/core/look_at_rotation.sv */
// Look-at rotation: each transfer brings an eye and a target point (signed Q16.16) and
// returns one quaternion (signed Q2.14 by default) that turns local +z towards the target
// with +y kept near world up, plus a degenerate flag. When the eye-to-target vector is
// shorter than min_distance, points straight along up, or the quaternion vanishes, the
// previously held rotation is returned with the flag set. Items are handled one at a time
// and a full solve runs through the shared bit-serial units for products, quotients and
// square roots. A new item is taken while the previous result still waits in the output
// register.
`default_nettype none

module look_at_rotation #(
  parameter int unsigned QUAT_FRAC_BITS = lar_pkg::QuatFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lar_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lar_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);

  localparam logic [63:0] QuatOne = 64'd1 << QUAT_FRAC_BITS;
  localparam logic [63:0] UnitOne = 64'd1 << lar_pkg::UnitFracBits;

  lar_pkg::state_e state_q, state_d, ret_q;

  logic [15:0] min_dist_q;
  logic [15:0] held_q [4];
  logic [1:0]  idx_q;
  logic [1:0]  nlast_q;
  logic [2:0]  step_q;
  logic        quat_q;
  logic        ok_q;
  logic        deg_q;
  logic        wait_q;
  logic        out_valid_q;

  logic [32:0] d_q [3];
  logic [31:0] z_q [3];
  logic [31:0] x_q [3];
  logic [31:0] y_q [3];
  logic [63:0] vec_q [4];
  logic [63:0] mag_q [4];
  logic [3:0]  neg_q;
  logic [63:0] acc_q;
  logic [31:0] len_q;
  logic [31:0] root_q;
  lar_pkg::out_item_t out_q;

  logic        mul_start, mul_done;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        sqrt_start, sqrt_done;
  logic [63:0] sqrt_in;
  logic [31:0] sqrt_root;
  logic        div_start, div_done;
  logic [63:0] div_num, div_quo;
  logic [32:0] div_den;

  logic [32:0] absd [3];
  logic        far_w, par_w;
  logic [1:0]  zi, xi, ck;
  logic        cneg;
  logic [63:0] term;
  logic [63:0] orv;
  logic        scale_ok;
  logic [63:0] lim, nq;

  logic signed [33:0] m00, m01, m02, m10, m11, m12, m20, m21, m22, tr, arg;
  logic signed [33:0] num;
  logic [1:0]  br;
  logic [32:0] argu;
  logic [31:0] qmag;
  logic        qskip;

  function automatic logic [1:0] next3(input logic [1:0] v);
    logic [1:0] r;
    case (v)
      2'd0:    r = 2'd1;
      2'd1:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [33:0] sx(input logic [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  // distance tests
  always_comb begin
    far_w = 1'b0;
    for (int i = 0; i < 3; i++) begin
      absd[i] = d_q[i][32] ? (~d_q[i] + 33'd1) : d_q[i];
      if (absd[i] >= {17'd0, min_dist_q}) begin
        far_w = 1'b1;
      end
    end
    par_w = (d_q[0] == '0) && (d_q[2] == '0);
  end

  // cross product operand selection
  assign ck   = step_q[2:1];
  assign zi   = step_q[0] ? next3(next3(ck)) : next3(ck);
  assign xi   = step_q[0] ? next3(ck) : next3(next3(ck));
  assign cneg = z_q[zi][31] ^ x_q[xi][31];
  assign term = cneg ? (~mul_p + 64'd1) : mul_p;

  // rotation matrix, columns x, y, z
  assign m00 = sx(x_q[0]);
  assign m10 = sx(x_q[1]);
  assign m20 = sx(x_q[2]);
  assign m01 = sx(y_q[0]);
  assign m11 = sx(y_q[1]);
  assign m21 = sx(y_q[2]);
  assign m02 = sx(z_q[0]);
  assign m12 = sx(z_q[1]);
  assign m22 = sx(z_q[2]);
  assign tr  = m00 + m11 + m22;

  always_comb begin
    if (tr > 0) begin
      br  = 2'd0;
      arg = tr + 34'(UnitOne);
    end else if (m00 > m11 && m00 > m22) begin
      br  = 2'd1;
      arg = 34'(UnitOne) + m00 - m11 - m22;
    end else if (m11 > m22) begin
      br  = 2'd2;
      arg = 34'(UnitOne) + m11 - m00 - m22;
    end else begin
      br  = 2'd3;
      arg = 34'(UnitOne) + m22 - m00 - m11;
    end
    argu = arg[33] ? 33'd0 : arg[32:0];
  end

  always_comb begin
    num = '0;
    case (idx_q)
      2'd0: begin
        case (br)
          2'd1:    num = m21 - m12;
          2'd2:    num = m02 - m20;
          default: num = m10 - m01;
        endcase
      end
      2'd1: begin
        case (br)
          2'd0:    num = m21 - m12;
          2'd2:    num = m01 + m10;
          default: num = m02 + m20;
        endcase
      end
      2'd2: begin
        case (br)
          2'd0:    num = m02 - m20;
          2'd1:    num = m01 + m10;
          default: num = m12 + m21;
        endcase
      end
      default: begin
        case (br)
          2'd0:    num = m10 - m01;
          2'd1:    num = m02 + m20;
          default: num = m12 + m21;
        endcase
      end
    endcase
  end

  assign qmag  = num[33] ? 32'(-num) : num[31:0];
  assign qskip = (idx_q == br) || (root_q == '0);

  // normalisation helpers
  assign orv      = mag_q[0] | mag_q[1] | mag_q[2] | mag_q[3];
  assign scale_ok = (orv[63:30] == '0) && (orv[63:28] != '0);
  assign lim      = quat_q ? QuatOne : UnitOne;
  assign nq       = (div_quo > lim) ? lim : div_quo;

  // unit operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      lar_pkg::ST_DIST_SQ: begin
        mul_a = absd[idx_q][31:0];
        mul_b = absd[idx_q][31:0];
      end
      lar_pkg::ST_DIST_MIN: begin
        mul_a = {16'd0, min_dist_q};
        mul_b = {16'd0, min_dist_q};
      end
      lar_pkg::ST_CROSS: begin
        mul_a = z_q[zi][31] ? (~z_q[zi] + 32'd1) : z_q[zi];
        mul_b = x_q[xi][31] ? (~x_q[xi] + 32'd1) : x_q[xi];
      end
      lar_pkg::ST_NRM_SQ: begin
        mul_a = mag_q[idx_q][31:0];
        mul_b = mag_q[idx_q][31:0];
      end
      default: ;
    endcase
  end

  assign sqrt_in = (state_q == lar_pkg::ST_ROOT) ? {1'b0, argu, 30'd0} : acc_q;

  always_comb begin
    if (state_q == lar_pkg::ST_QUOT) begin
      div_num = {2'b00, qmag, 30'd0} + {32'd0, root_q};
      div_den = {root_q, 1'b0};
    end else begin
      div_num = (quat_q ? (mag_q[idx_q] << QUAT_FRAC_BITS)
                        : (mag_q[idx_q] << lar_pkg::UnitFracBits))
                + {33'd0, len_q[31:1]};
      div_den = {1'b0, len_q};
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lar_pkg::ST_IDLE:      if (in_valid_i) state_d = lar_pkg::ST_CHECK;
      lar_pkg::ST_CHECK: begin
        if (par_w) begin
          state_d = lar_pkg::ST_FINISH;
        end else if (far_w) begin
          state_d = lar_pkg::ST_LOAD_Z;
        end else begin
          state_d = lar_pkg::ST_DIST_SQ;
        end
      end
      lar_pkg::ST_DIST_SQ:   if (mul_done && idx_q == 2'd2) state_d = lar_pkg::ST_DIST_MIN;
      lar_pkg::ST_DIST_MIN: begin
        if (mul_done) begin
          state_d = (acc_q < mul_p) ? lar_pkg::ST_FINISH : lar_pkg::ST_LOAD_Z;
        end
      end
      lar_pkg::ST_LOAD_Z:    state_d = lar_pkg::ST_NRM_MAG;
      lar_pkg::ST_SAVE_Z:    state_d = lar_pkg::ST_NRM_MAG;
      lar_pkg::ST_SAVE_X:    state_d = lar_pkg::ST_CROSS;
      lar_pkg::ST_CROSS:     if (mul_done && step_q == 3'd5) state_d = lar_pkg::ST_NRM_MAG;
      lar_pkg::ST_SAVE_Y:    state_d = lar_pkg::ST_ROOT;
      lar_pkg::ST_ROOT:      if (sqrt_done) state_d = lar_pkg::ST_QUOT;
      lar_pkg::ST_QUOT: begin
        if ((qskip || div_done) && idx_q == 2'd3) state_d = lar_pkg::ST_NRM_MAG;
      end
      lar_pkg::ST_SAVE_Q:    state_d = lar_pkg::ST_FINISH;
      lar_pkg::ST_NRM_MAG:   state_d = lar_pkg::ST_NRM_SCALE;
      lar_pkg::ST_NRM_SCALE: begin
        if (orv == '0) begin
          state_d = ret_q;
        end else if (scale_ok) begin
          state_d = lar_pkg::ST_NRM_SQ;
        end
      end
      lar_pkg::ST_NRM_SQ:    if (mul_done && idx_q == nlast_q) state_d = lar_pkg::ST_NRM_ROOT;
      lar_pkg::ST_NRM_ROOT:  if (sqrt_done) state_d = lar_pkg::ST_NRM_DIV;
      lar_pkg::ST_NRM_DIV:   if (div_done && idx_q == nlast_q) state_d = ret_q;
      lar_pkg::ST_FINISH:    if (!out_valid_q || out_ready_i) state_d = lar_pkg::ST_IDLE;
      default:               state_d = lar_pkg::ST_IDLE;
    endcase
  end

  // handshake and unit starts
  always_comb begin
    in_ready_o = (state_q == lar_pkg::ST_IDLE);
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state_q)
      lar_pkg::ST_DIST_SQ, lar_pkg::ST_DIST_MIN,
      lar_pkg::ST_CROSS, lar_pkg::ST_NRM_SQ:     mul_start  = !wait_q;
      lar_pkg::ST_ROOT, lar_pkg::ST_NRM_ROOT:    sqrt_start = !wait_q;
      lar_pkg::ST_NRM_DIV:                       div_start  = !wait_q;
      lar_pkg::ST_QUOT:                          div_start  = !wait_q && !qskip;
      default: ;
    endcase
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lar_pkg::ST_IDLE;
      ret_q       <= lar_pkg::ST_IDLE;
      min_dist_q  <= lar_pkg::MinDistReset;
      held_q[0]   <= QuatOne[15:0];
      held_q[1]   <= '0;
      held_q[2]   <= '0;
      held_q[3]   <= '0;
      idx_q       <= '0;
      nlast_q     <= '0;
      step_q      <= '0;
      quat_q      <= 1'b0;
      ok_q        <= 1'b0;
      deg_q       <= 1'b0;
      wait_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        min_dist_q <= cfg_wdata_i;
      end
      if (mul_start || sqrt_start || div_start) begin
        wait_q <= 1'b1;
      end else if (mul_done || sqrt_done || div_done) begin
        wait_q <= 1'b0;
      end
      if (state_q == lar_pkg::ST_FINISH && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        lar_pkg::ST_IDLE: begin
          if (in_valid_i) begin
            deg_q <= 1'b0;
            idx_q <= '0;
          end
        end
        lar_pkg::ST_CHECK:    if (par_w) deg_q <= 1'b1;
        lar_pkg::ST_DIST_SQ:  if (mul_done) idx_q <= idx_q + 2'd1;
        lar_pkg::ST_DIST_MIN: if (mul_done && acc_q < mul_p) deg_q <= 1'b1;
        lar_pkg::ST_LOAD_Z: begin
          ret_q   <= lar_pkg::ST_SAVE_Z;
          nlast_q <= 2'd2;
          quat_q  <= 1'b0;
        end
        lar_pkg::ST_SAVE_Z: begin
          ret_q   <= lar_pkg::ST_SAVE_X;
          nlast_q <= 2'd2;
          quat_q  <= 1'b0;
        end
        lar_pkg::ST_SAVE_X:   step_q <= '0;
        lar_pkg::ST_CROSS: begin
          if (mul_done) begin
            step_q <= step_q + 3'd1;
            if (step_q == 3'd5) begin
              ret_q   <= lar_pkg::ST_SAVE_Y;
              nlast_q <= 2'd2;
              quat_q  <= 1'b0;
            end
          end
        end
        lar_pkg::ST_ROOT:     if (sqrt_done) idx_q <= '0;
        lar_pkg::ST_QUOT: begin
          if (qskip || div_done) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) begin
              ret_q   <= lar_pkg::ST_SAVE_Q;
              nlast_q <= 2'd3;
              quat_q  <= 1'b1;
            end
          end
        end
        lar_pkg::ST_SAVE_Q: begin
          if (ok_q) begin
            for (int i = 0; i < 4; i++) begin
              held_q[i] <= vec_q[i][15:0];
            end
          end else begin
            deg_q <= 1'b1;
          end
        end
        lar_pkg::ST_NRM_SCALE: begin
          if (orv == '0) begin
            ok_q <= 1'b0;
          end else if (scale_ok) begin
            idx_q <= '0;
          end
        end
        lar_pkg::ST_NRM_SQ: begin
          if (mul_done) begin
            idx_q <= (idx_q == nlast_q) ? 2'd0 : idx_q + 2'd1;
          end
        end
        lar_pkg::ST_NRM_DIV: begin
          if (div_done) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == nlast_q) begin
              ok_q <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      lar_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          d_q[0] <= {in_data_i.target_x[31], in_data_i.target_x}
                    - {in_data_i.eye_x[31], in_data_i.eye_x};
          d_q[1] <= {in_data_i.target_y[31], in_data_i.target_y}
                    - {in_data_i.eye_y[31], in_data_i.eye_y};
          d_q[2] <= {in_data_i.target_z[31], in_data_i.target_z}
                    - {in_data_i.eye_z[31], in_data_i.eye_z};
        end
      end
      lar_pkg::ST_CHECK:    acc_q <= '0;
      lar_pkg::ST_DIST_SQ:  if (mul_done) acc_q <= acc_q + mul_p;
      lar_pkg::ST_LOAD_Z: begin
        for (int i = 0; i < 3; i++) begin
          vec_q[i] <= {{31{d_q[i][32]}}, d_q[i]};
        end
        vec_q[3] <= '0;
      end
      lar_pkg::ST_SAVE_Z: begin
        for (int i = 0; i < 3; i++) begin
          z_q[i] <= vec_q[i][31:0];
        end
        // up cross z
        vec_q[0] <= {{31{d_q[2][32]}}, d_q[2]};
        vec_q[1] <= '0;
        vec_q[2] <= ~{{31{d_q[0][32]}}, d_q[0]} + 64'd1;
        vec_q[3] <= '0;
      end
      lar_pkg::ST_SAVE_X: begin
        for (int i = 0; i < 3; i++) begin
          x_q[i] <= vec_q[i][31:0];
        end
      end
      lar_pkg::ST_CROSS: begin
        if (mul_done) begin
          if (!step_q[0]) begin
            acc_q <= term;
          end else begin
            vec_q[ck] <= acc_q - term;
          end
          if (step_q == 3'd5) begin
            vec_q[3] <= '0;
          end
        end
      end
      lar_pkg::ST_SAVE_Y: begin
        for (int i = 0; i < 3; i++) begin
          y_q[i] <= vec_q[i][31:0];
        end
      end
      lar_pkg::ST_ROOT:     if (sqrt_done) root_q <= sqrt_root;
      lar_pkg::ST_QUOT: begin
        if (qskip) begin
          vec_q[idx_q] <= (idx_q == br) ? {33'd0, root_q[31:1]} : 64'd0;
        end else if (div_done) begin
          vec_q[idx_q] <= num[33] ? (~div_quo + 64'd1) : div_quo;
        end
      end
      lar_pkg::ST_NRM_MAG: begin
        for (int i = 0; i < 4; i++) begin
          if (2'(i) <= nlast_q) begin
            neg_q[i] <= vec_q[i][63];
            mag_q[i] <= vec_q[i][63] ? (~vec_q[i] + 64'd1) : vec_q[i];
          end else begin
            neg_q[i] <= 1'b0;
            mag_q[i] <= '0;
          end
        end
      end
      lar_pkg::ST_NRM_SCALE: begin
        if (orv == '0) begin
          for (int i = 0; i < 4; i++) begin
            vec_q[i] <= '0;
          end
        end else if (orv[63:30] != '0) begin
          for (int i = 0; i < 4; i++) begin
            mag_q[i] <= mag_q[i] >> 1;
          end
        end else if (orv[63:28] == '0) begin
          for (int i = 0; i < 4; i++) begin
            mag_q[i] <= mag_q[i] << 1;
          end
        end else begin
          acc_q <= '0;
        end
      end
      lar_pkg::ST_NRM_SQ:   if (mul_done) acc_q <= acc_q + mul_p;
      lar_pkg::ST_NRM_ROOT: if (sqrt_done) len_q <= sqrt_root;
      lar_pkg::ST_NRM_DIV: begin
        if (div_done) begin
          vec_q[idx_q] <= neg_q[idx_q] ? (~nq + 64'd1) : nq;
        end
      end
      lar_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.quat_w     <= held_q[0];
          out_q.quat_x     <= held_q[1];
          out_q.quat_y     <= held_q[2];
          out_q.quat_z     <= held_q[3];
          out_q.degenerate <= deg_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  lar_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  lar_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sqrt_in),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  lar_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

endmodule

`default_nettype wire

/* test/testbench.sv */
`default_nettype none

module testbench;
  import lar_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  look_at_rotation dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  localparam longint UnitOne = longint'(1) << 30;
  localparam int QuatOne = 1 << QuatFracBits;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  longint unsigned min_dist;
  longint          held_quat [4];
  out_item_t       pending_quats [$];
  int              errors = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("look_at_rotation regression: fail");
    $finish;
  end

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d, want %0d", what, got, want);
  endtask

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic bit unit_scale(input longint v [4], input int n, input int fb,
                                    output longint o [4]);
    longint unsigned mag [4];
    longint unsigned mx, sum, len, q;
    bit neg [4];
    mx = 0;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      o[i] = 0;
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? -v[i] : v[i];
      if (i < n && mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) return 1'b0;
    while (mx >= (longint'(1) << 30)) begin
      for (int i = 0; i < 4; i++) mag[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (longint'(1) << 28)) begin
      for (int i = 0; i < 4; i++) mag[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < n; i++) sum += mag[i] * mag[i];
    len = int_root(sum);
    for (int i = 0; i < n; i++) begin
      q = ((mag[i] << fb) + len / 2) / len;
      if (q > (longint'(1) << fb)) q = longint'(1) << fb;
      o[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic longint quot_unit(input longint num, input longint den);
    longint unsigned m, q;
    if (den <= 0) return 0;
    m = (num < 0) ? -num : num;
    q = ((m << 30) + longint'(den) / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint root_unit(input longint v);
    if (v < 0) v = 0;
    return longint'(int_root(longint'(v) << 30));
  endfunction

  function automatic out_item_t solve_look_at(input in_item_t it);
    longint d [4], xs [4], yr [4], zv [4], xv [4], yv [4], q [4], qn [4];
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22, tr, s, md;
    longint unsigned ss;
    bit degen, far_off;
    out_item_t res;
    degen = 1'b0;
    d[0] = longint'(it.target_x) - longint'(it.eye_x);
    d[1] = longint'(it.target_y) - longint'(it.eye_y);
    d[2] = longint'(it.target_z) - longint'(it.eye_z);
    d[3] = 0;
    md = longint'(min_dist);
    far_off = 1'b0;
    for (int i = 0; i < 3; i++) if (d[i] >= md || -d[i] >= md) far_off = 1'b1;
    if (!far_off) begin
      ss = 0;
      for (int i = 0; i < 3; i++) ss += d[i] * d[i];
      if (ss < min_dist * min_dist) degen = 1'b1;
    end
    if (d[0] == 0 && d[2] == 0) degen = 1'b1;
    if (!degen) begin
      void'(unit_scale(d, 3, 30, zv));
      xs[0] = d[2];
      xs[1] = 0;
      xs[2] = -d[0];
      xs[3] = 0;
      void'(unit_scale(xs, 3, 30, xv));
      yr[0] = zv[1] * xv[2] - zv[2] * xv[1];
      yr[1] = zv[2] * xv[0] - zv[0] * xv[2];
      yr[2] = zv[0] * xv[1] - zv[1] * xv[0];
      yr[3] = 0;
      void'(unit_scale(yr, 3, 30, yv));
      m00 = xv[0]; m01 = yv[0]; m02 = zv[0];
      m10 = xv[1]; m11 = yv[1]; m12 = zv[1];
      m20 = xv[2]; m21 = yv[2]; m22 = zv[2];
      tr = m00 + m11 + m22;
      if (tr > 0) begin
        s = root_unit(tr + UnitOne);
        q[0] = s / 2;
        q[1] = quot_unit(m21 - m12, 2 * s);
        q[2] = quot_unit(m02 - m20, 2 * s);
        q[3] = quot_unit(m10 - m01, 2 * s);
      end else if (m00 > m11 && m00 > m22) begin
        s = 2 * root_unit(UnitOne + m00 - m11 - m22);
        q[0] = quot_unit(m21 - m12, s);
        q[1] = s / 4;
        q[2] = quot_unit(m01 + m10, s);
        q[3] = quot_unit(m02 + m20, s);
      end else if (m11 > m22) begin
        s = 2 * root_unit(UnitOne + m11 - m00 - m22);
        q[0] = quot_unit(m02 - m20, s);
        q[1] = quot_unit(m01 + m10, s);
        q[2] = s / 4;
        q[3] = quot_unit(m12 + m21, s);
      end else begin
        s = 2 * root_unit(UnitOne + m22 - m00 - m11);
        q[0] = quot_unit(m10 - m01, s);
        q[1] = quot_unit(m02 + m20, s);
        q[2] = quot_unit(m12 + m21, s);
        q[3] = s / 4;
      end
      if (unit_scale(q, 4, QuatFracBits, qn)) begin
        for (int i = 0; i < 4; i++) held_quat[i] = qn[i];
      end else begin
        degen = 1'b1;
      end
    end
    res.quat_w = held_quat[0][15:0];
    res.quat_x = held_quat[1][15:0];
    res.quat_y = held_quat[2][15:0];
    res.quat_z = held_quat[3][15:0];
    res.degenerate = degen;
    return res;
  endfunction

  function automatic in_item_t points(input int ex, input int ey, input int ez,
                                      input int tx, input int ty, input int tz);
    in_item_t it;
    it.eye_x = ex; it.eye_y = ey; it.eye_z = ez;
    it.target_x = tx; it.target_y = ty; it.target_z = tz;
    return it;
  endfunction

  function automatic in_item_t random_points();
    in_item_t it;
    int kind, span;
    it = points($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 1) == 1) ? 40 : 1 << $urandom_range(4, 24);
    if (kind < 4) begin
      // nearby target, short to moderate offsets
      it.target_x = it.eye_x + $urandom_range(0, 2 * span) - span;
      it.target_y = it.eye_y + $urandom_range(0, 2 * span) - span;
      it.target_z = it.eye_z + $urandom_range(0, 2 * span) - span;
    end else if (kind == 4) begin
      it.target_x = it.eye_x;
      it.target_z = it.eye_z;
    end else if (kind == 5) begin
      it.target_x = it.eye_x + $urandom_range(0, 2);
      it.target_z = it.eye_z - $urandom_range(0, 2);
    end
    return it;
  endfunction

  task automatic send_points(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t pred;
    int gap;
    pred = solve_look_at(it);
    pending_quats.push_back(typed ? want : pred);
    gap = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120) :
          ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 3);
    if (gap > 0 && in_valid_i) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic set_min_dist(input logic [15:0] v);
    in_valid_i <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    min_dist = 64'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // receiver side with random back-pressure
  initial begin
    int len;
    forever begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
      out_ready_i <= ($urandom_range(0, 3) != 0);
      repeat (len) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_q;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_quats.size() == 0) begin
        report("unexpected transfer", out_data_o.quat_w, 0);
      end else begin
        exp_q = pending_quats.pop_front();
        if (out_data_o.quat_w !== exp_q.quat_w)
          report("quat_w", out_data_o.quat_w, exp_q.quat_w);
        if (out_data_o.quat_x !== exp_q.quat_x)
          report("quat_x", out_data_o.quat_x, exp_q.quat_x);
        if (out_data_o.quat_y !== exp_q.quat_y)
          report("quat_y", out_data_o.quat_y, exp_q.quat_y);
        if (out_data_o.quat_z !== exp_q.quat_z)
          report("quat_z", out_data_o.quat_z, exp_q.quat_z);
        if (out_data_o.degenerate !== exp_q.degenerate)
          report("degenerate", out_data_o.degenerate, exp_q.degenerate);
      end
    end
  end

  initial begin
    stim_row_t rows [$];
    stim_row_t r;
    int one;
    logic [15:0] dist_steps [4];
    one = 1 << 16;
    min_dist = 64'(MinDistReset);
    held_quat[0] = QuatOne;
    held_quat[1] = 0;
    held_quat[2] = 0;
    held_quat[3] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    r.typed = 1'b1;
    // zero offset, straight up, too short: identity held
    r.want = '{quat_w: 16'(QuatOne), quat_x: '0, quat_y: '0, quat_z: '0, degenerate: 1'b1};
    r.item = points(5, 6, 7, 5, 6, 7); rows.push_back(r);
    r.item = points(0, 0, 0, 0, 5 * one, 0); rows.push_back(r);
    r.item = points(0, 0, 0, 3, 0, 2); rows.push_back(r);
    // facing +z already, and at exactly the minimum distance
    r.want.degenerate = 1'b0;
    r.item = points(0, 0, 0, 0, 0, one); rows.push_back(r);
    r.item = points(0, 0, 0, 0, 0, 7); rows.push_back(r);
    r.typed = 1'b0;
    r.item = points(0, 0, 0, 0, 0, -one); rows.push_back(r);
    r.item = points(0, 0, 0, one, 0, 0); rows.push_back(r);
    r.item = points(0, 0, 0, -one, 0, 0); rows.push_back(r);
    r.item = points(one, one, one, 0, 0, 0); rows.push_back(r);
    r.item = points(0, 0, 0, 5, 0, 4); rows.push_back(r);
    r.item = points(0, 0, 0, 1, 32'sh7fff_ffff, 0); rows.push_back(r);
    r.item = points(0, 0, 0, 0, 32'sh8000_0000, -1); rows.push_back(r);
    r.item = points(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                    32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff); rows.push_back(r);
    r.item = points(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                    32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000); rows.push_back(r);
    r.item = points(32'sh7fff_ffff, 0, 32'sh8000_0000,
                    32'sh8000_0000, 0, 32'sh7fff_ffff); rows.push_back(r);
    r.item = points(-1, -1, -1, -1, one, 0); rows.push_back(r);
    r.item = points(0, 0, 0, 3 * one, -2 * one, -one); rows.push_back(r);
    foreach (rows[i]) send_points(rows[i].item, rows[i].typed, rows[i].want);

    dist_steps[0] = 16'd0;
    dist_steps[1] = 16'hffff;
    dist_steps[2] = 16'($urandom_range(1, 200));
    dist_steps[3] = 16'($urandom);
    foreach (dist_steps[p]) begin
      set_min_dist(dist_steps[p]);
      repeat (400) send_points(random_points(), 1'b0, '0);
    end

    in_valid_i <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("look_at_rotation regression: pass");
    end else begin
      $display("look_at_rotation regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
rtl/core/lar_pkg.sv
rtl/core/lar_mul.sv
rtl/core/lar_div.sv
rtl/core/lar_sqrt.sv
rtl/core/look_at_rotation.sv
test/testbench.sv
